// ===== design/rcm_pkg.sv =====
package rcm_pkg;

   localparam int CHANNEL_BITS_DEFAULT = 16;

   localparam int INDEX_BITS = 16;
   localparam int COUNT_BITS = 15;
   // longest segment is 32767 / 5 = 6553
   localparam int SEG_BITS   = 13;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(5);

   // floor(x / 5) == (x * 26215) >> 17 for every 15-bit x
   localparam int              DIV5_SHIFT = 17;
   localparam logic [14:0]     DIV5_MULT  = 15'd26215;

   typedef enum logic [2:0] {
      SEG_RED_YELLOW  = 3'd0,
      SEG_YELLOW_GREEN = 3'd1,
      SEG_GREEN_CYAN  = 3'd2,
      SEG_CYAN_BLUE   = 3'd3,
      SEG_BLUE_MAGENTA = 3'd4
   } seg_type;

   typedef struct packed {
      seg_type seg;
      logic    bad;
   } rcm_tag_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] total;
      logic [SEG_BITS-1:0]   seglen;
      logic                  div_ok;
   } rcm_cfg_type;

endpackage

// ===== design/rcm_csr.sv =====
module rcm_csr
   import rcm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output rcm_cfg_type              cfg
);

   rcm_cfg_type             cfg_ff;
   rcm_cfg_type             cfg_in;
   logic                    wr_en;
   logic [COUNT_BITS-1:0]   wr_count;
   logic [29:0]             prod;
   logic [5:0]              nib_sum;

   // 16 = 1 mod 5, so the nibble sum keeps the residue
   function automatic logic mult_of_five(input logic [5:0] val);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k <= 12; k++) begin
         if (val == 6'(5 * k)) hit = 1'b1;
      end
      return hit;
   endfunction

   assign wr_en    = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign wr_count = csr_pwdata[COUNT_BITS-1:0];
   assign prod     = 30'(wr_count) * 30'(DIV5_MULT);
   assign nib_sum  = 6'(wr_count[3:0]) + 6'(wr_count[7:4]) + 6'(wr_count[11:8])
                   + 6'(wr_count[14:12]);

   always_comb begin
      cfg_in        = cfg_ff;
      cfg_in.total  = wr_count;
      cfg_in.seglen = prod[DIV5_SHIFT +: SEG_BITS];
      cfg_in.div_ok = mult_of_five(nib_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total  <= COUNT_RESET;
         cfg_ff.seglen <= SEG_BITS'(1);
         cfg_ff.div_ok <= 1'b1;
      end else if (wr_en) begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg        = cfg_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? '0 : CSR_DATA_BITS'(cfg_ff.total);

endmodule

// ===== design/rcm_front.sv =====
module rcm_front
   import rcm_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  rcm_cfg_type             cfg,
   input  logic                    in_valid,
   input  logic [INDEX_BITS-1:0]   in_index,
   output logic                    out_valid,
   output logic [SEG_BITS-1:0]     out_rem,
   output logic [CHANNEL_BITS-1:0] out_word,
   output rcm_tag_type             out_tag
);

   logic [COUNT_BITS-1:0]   raw;
   logic [COUNT_BITS-1:0]   m1, m2, m3, m4;
   logic                    ge1, ge2, ge3, ge4;
   logic [COUNT_BITS-1:0]   mult_in;
   rcm_tag_type             tag_in;

   logic                    v1_ff;
   logic [COUNT_BITS-1:0]   raw_ff;
   logic [COUNT_BITS-1:0]   mult_ff;
   rcm_tag_type             tag1_ff;

   logic [COUNT_BITS-1:0]   pos_m1;
   logic [COUNT_BITS-1:0]   pos_hi;
   logic [SEG_BITS-1:0]     rem_in;
   logic [CHANNEL_BITS-1:0] word_in;

   logic                    v2_ff;
   logic [SEG_BITS-1:0]     rem_ff;
   logic [CHANNEL_BITS-1:0] word_ff;
   rcm_tag_type             tag2_ff;

   // first cell: segment boundaries
   assign raw = in_index[COUNT_BITS-1:0];
   assign m1  = COUNT_BITS'(cfg.seglen);
   assign m2  = COUNT_BITS'({cfg.seglen, 1'b0});
   assign m3  = m1 + m2;
   assign m4  = COUNT_BITS'({cfg.seglen, 2'b00});
   assign ge1 = raw >= m1;
   assign ge2 = raw >= m2;
   assign ge3 = raw >= m3;
   assign ge4 = raw >= m4;

   always_comb begin
      tag_in.bad = in_index[INDEX_BITS-1] || (raw >= cfg.total) || !cfg.div_ok;
      priority if (ge4) begin
         tag_in.seg = SEG_BLUE_MAGENTA;
         mult_in    = m4;
      end else if (ge3) begin
         tag_in.seg = SEG_CYAN_BLUE;
         mult_in    = m3;
      end else if (ge2) begin
         tag_in.seg = SEG_GREEN_CYAN;
         mult_in    = m2;
      end else if (ge1) begin
         tag_in.seg = SEG_YELLOW_GREEN;
         mult_in    = m1;
      end else begin
         tag_in.seg = SEG_RED_YELLOW;
         mult_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         raw_ff  <= raw;
         mult_ff <= mult_in;
         tag1_ff <= tag_in;
      end
   end

   // second cell: dividend pos * (2^n - 1) split into high part floor(./2^n) and low part -pos
   // the high part is pos - ceil(pos / 2^n), which is pos-1 for wide channels
   assign pos_m1  = raw_ff + ~mult_ff;
   assign pos_hi  = pos_m1 - (pos_m1 >> CHANNEL_BITS);
   assign rem_in  = (raw_ff == mult_ff) ? '0 : pos_hi[SEG_BITS-1:0];
   assign word_in = CHANNEL_BITS'(mult_ff) - CHANNEL_BITS'(raw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         word_ff <= word_in;
         tag2_ff <= tag1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_rem   = rem_ff;
   assign out_word  = word_ff;
   assign out_tag   = tag2_ff;

endmodule

// ===== design/rcm_div_cell.sv =====
module rcm_div_cell
   import rcm_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [SEG_BITS-1:0]     seglen,
   input  logic                    in_valid,
   input  logic [SEG_BITS-1:0]     in_rem,
   input  logic [CHANNEL_BITS-1:0] in_word,
   input  rcm_tag_type             in_tag,
   output logic                    out_valid,
   output logic [SEG_BITS-1:0]     out_rem,
   output logic [CHANNEL_BITS-1:0] out_word,
   output rcm_tag_type             out_tag
);

   logic [SEG_BITS:0]       rem_shift;
   logic [SEG_BITS:0]       rem_diff;
   logic                    fits;
   logic [SEG_BITS-1:0]     rem_in;
   logic [CHANNEL_BITS-1:0] word_in;

   logic                    valid_ff;
   logic [SEG_BITS-1:0]     rem_ff;
   logic [CHANNEL_BITS-1:0] word_ff;
   rcm_tag_type             tag_ff;

   // one restoring step: dividend bits leave the top of the word, quotient bits enter below
   assign rem_shift = {in_rem, in_word[CHANNEL_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, seglen};
   assign fits      = rem_shift >= {1'b0, seglen};
   assign rem_in    = fits ? rem_diff[SEG_BITS-1:0] : rem_shift[SEG_BITS-1:0];
   assign word_in   = {in_word[CHANNEL_BITS-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         word_ff <= word_in;
         tag_ff  <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_word  = word_ff;
   assign out_tag   = tag_ff;

endmodule

// ===== design/rcm_out.sv =====
module rcm_out
   import rcm_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   output logic                    advance,
   input  logic                    in_valid,
   input  logic [CHANNEL_BITS-1:0] in_ramp,
   input  rcm_tag_type             in_tag,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CHANNEL_BITS-1:0] rsp_red,
   output logic [CHANNEL_BITS-1:0] rsp_green,
   output logic [CHANNEL_BITS-1:0] rsp_blue,
   output logic                    rsp_bad_request
);

   localparam logic [CHANNEL_BITS-1:0] FULL = '1;

   logic [CHANNEL_BITS-1:0] up, down;
   logic [CHANNEL_BITS-1:0] red_in, green_in, blue_in;

   logic                    rsp_valid_ff;
   logic                    skid_valid_ff;
   logic                    load_rsp, load_skid, move_skid;
   logic [CHANNEL_BITS-1:0] red_ff, green_ff, blue_ff;
   logic                    bad_ff;
   logic [CHANNEL_BITS-1:0] skid_red_ff, skid_green_ff, skid_blue_ff;
   logic                    skid_bad_ff;

   assign up   = in_ramp;
   assign down = ~in_ramp;

   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      if (!in_tag.bad) begin
         unique case (in_tag.seg)
            SEG_RED_YELLOW: begin
               red_in   = FULL;
               green_in = up;
            end
            SEG_YELLOW_GREEN: begin
               red_in   = down;
               green_in = FULL;
            end
            SEG_GREEN_CYAN: begin
               green_in = FULL;
               blue_in  = up;
            end
            SEG_CYAN_BLUE: begin
               green_in = down;
               blue_in  = FULL;
            end
            default: begin
               red_in  = up;
               blue_in = FULL;
            end
         endcase
      end
   end

   assign advance   = !skid_valid_ff;
   assign move_skid = skid_valid_ff && !rsp_stall;
   assign load_rsp  = !skid_valid_ff && in_valid && (!rsp_valid_ff || !rsp_stall);
   assign load_skid = !skid_valid_ff && in_valid && rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (move_skid) begin
            skid_valid_ff <= 1'b0;
         end else if (load_skid) begin
            skid_valid_ff <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!skid_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move_skid) begin
         red_ff   <= skid_red_ff;
         green_ff <= skid_green_ff;
         blue_ff  <= skid_blue_ff;
         bad_ff   <= skid_bad_ff;
      end else if (load_rsp) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         bad_ff   <= in_tag.bad;
      end
      if (load_skid) begin
         skid_red_ff   <= red_in;
         skid_green_ff <= green_in;
         skid_blue_ff  <= blue_in;
         skid_bad_ff   <= in_tag.bad;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;
   assign rsp_bad_request = bad_ff;

endmodule

// ===== design/rainbow_colormap.sv =====
// Five-segment rainbow colormap (red, yellow, green, cyan, blue, magenta). One request is taken
// every clock while req_stall is low, and each produces one response: the front cells find the
// segment and the offset within it, then a row of CHANNEL_BITS divider cells forms the ramp
// floor(pos * (2^CHANNEL_BITS - 1) / seglen) one quotient bit per cell, and a last register
// holds the color. A two-entry output buffer lets a new request in while a response waits;
// req_stall rises only once that buffer is full. The color count sits at byte address 0 of the
// register port, resets to 5 and must be a multiple of five; otherwise, or for an index outside
// 0 to count-1, bad_request is set and all channels read zero. Write it only while idle.
module rainbow_colormap
   import rcm_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [INDEX_BITS-1:0]    req_color_index,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CHANNEL_BITS-1:0]  rsp_red,
   output logic [CHANNEL_BITS-1:0]  rsp_green,
   output logic [CHANNEL_BITS-1:0]  rsp_blue,
   output logic                     rsp_bad_request
);

   rcm_cfg_type             cfg;
   logic                    advance;

   logic                    cell_valid [0:CHANNEL_BITS];
   logic [SEG_BITS-1:0]     cell_rem   [0:CHANNEL_BITS];
   logic [CHANNEL_BITS-1:0] cell_word  [0:CHANNEL_BITS];
   rcm_tag_type             cell_tag   [0:CHANNEL_BITS];

   assign req_stall = !advance;

   rcm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rcm_front #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_index  (req_color_index),
      .out_valid (cell_valid[0]),
      .out_rem   (cell_rem[0]),
      .out_word  (cell_word[0]),
      .out_tag   (cell_tag[0])
   );

   for (genvar i = 0; i < CHANNEL_BITS; i++) begin : g_cell
      rcm_div_cell #(
         .CHANNEL_BITS (CHANNEL_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .seglen    (cfg.seglen),
         .in_valid  (cell_valid[i]),
         .in_rem    (cell_rem[i]),
         .in_word   (cell_word[i]),
         .in_tag    (cell_tag[i]),
         .out_valid (cell_valid[i+1]),
         .out_rem   (cell_rem[i+1]),
         .out_word  (cell_word[i+1]),
         .out_tag   (cell_tag[i+1])
      );
   end

   rcm_out #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_out (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (cell_valid[CHANNEL_BITS]),
      .in_ramp         (cell_word[CHANNEL_BITS]),
      .in_tag          (cell_tag[CHANNEL_BITS]),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_bad_request (rsp_bad_request)
   );

endmodule
